>>> src/lsc_pkg.sv
package lsc_pkg;

  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 16;
  localparam int SLOT_W   = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACCESS    = 2'd0,
    ACT_MARK      = 2'd1,
    ACT_FLUSH_ONE = 2'd2,
    ACT_FLUSH_ALL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_DIRTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic mark;
    logic access;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t act;
    logic    dirty_found;
    logic    flush_last;
    logic    out_free;
  } sts_t;

endpackage

>>> src/lsc_if.sv
interface lsc_in_if import lsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BLOCK_W-1:0]  block_number;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, action, block_number, slot_index, input ready);
  modport sink   (input valid, action, block_number, slot_index, output ready);
endinterface

interface lsc_out_if import lsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic               hit;
  logic               write_back;
  logic [BLOCK_W-1:0] write_back_block;
  logic               last;

  modport source (output valid, slot, hit, write_back, write_back_block, last, input ready);
  modport sink   (input valid, slot, hit, write_back, write_back_block, last, output ready);
endinterface

>>> src/lru_slot_cache_core.sv
// Directory of a fully associative write-back cache with LRU replacement.
// Each request is latched on the accepting edge, then looked up in S_EXEC, where its result is registered.
// No new request is taken until the current one is done; flush all writes back one dirty slot per pass.
// A full result register that is not drained stalls the lookup cycle, and input acceptance with it.
// Reset (synchronous, rst_n low): all slots free, tags zero, rank = slot index, no result pending.
module lru_slot_cache_core import lsc_pkg::*; #(
  parameter int SLOTS    = 8,
  parameter int TAG_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  lsc_in_if.sink    in_if,
  lsc_out_if.source out_if
);

  cmd_t cmd;    // per-cycle datapath commands from the sequencer
  sts_t sts;    // lookup status fed back to the sequencer
  logic in_ready;

  // Sequencer: latch in S_IDLE, then lookup/update in S_EXEC, one pass per result.
  lsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_if.ready = in_ready;

  // Tag/status/rank lanes with parallel compare, priority pick and result register.
  lsc_datapath #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_if.action),
    .in_block_number      (in_if.block_number),
    .in_slot_index        (in_if.slot_index),
    .out_valid            (out_if.valid),
    .out_ready            (out_if.ready),
    .out_slot             (out_if.slot),
    .out_hit              (out_if.hit),
    .out_write_back       (out_if.write_back),
    .out_write_back_block (out_if.write_back_block),
    .out_last             (out_if.last)
  );

endmodule

>>> src/lsc_ctrl.sv
module lsc_ctrl import lsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.act)
          ACT_MARK: begin
            cmd.mark  = 1'b1;
            state_nxt = S_IDLE;
          end
          ACT_ACCESS: begin
            if (sts.out_free) begin
              cmd.access = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          ACT_FLUSH_ONE, ACT_FLUSH_ALL: begin
            // flush all stays here, one write-back per pass
            if (!sts.dirty_found) begin
              state_nxt = S_IDLE;
            end else if (sts.out_free) begin
              cmd.flush = 1'b1;
              if (sts.flush_last) begin
                state_nxt = S_IDLE;
              end
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> src/lsc_datapath.sv
module lsc_datapath import lsc_pkg::*; #(
  parameter int SLOTS    = 8,
  parameter int TAG_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [BLOCK_W-1:0] in_block_number,
  input  logic [SLOT_W-1:0]  in_slot_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_hit,
  output logic               out_write_back,
  output logic [BLOCK_W-1:0] out_write_back_block,
  output logic               out_last
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [SLOTS-1:0]  ONE_V    = SLOTS'(1);
  localparam logic [SLOTS-1:0]  TOP_V    = ONE_V << (SLOTS - 1);
  localparam logic [IDX_W-1:0]  LRU_RANK = IDX_W'(SLOTS - 1);

  // latched transaction
  action_t             act_r;
  logic [TAG_BITS-1:0] blk_r;
  logic [SLOT_W-1:0]   cur_r;

  // directory
  logic [TAG_BITS-1:0] tag_r  [SLOTS];
  logic [TAG_BITS-1:0] tag_nxt[SLOTS];
  status_t             stat_r  [SLOTS];
  status_t             stat_nxt[SLOTS];
  logic [IDX_W-1:0]    rank_r  [SLOTS];
  logic [IDX_W-1:0]    rank_nxt[SLOTS];

  // result register
  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_hit_r;
  logic               out_wb_r;
  logic [BLOCK_W-1:0] out_wbb_r;
  logic               out_last_r;

  logic [SLOTS-1:0] match_v, free_v, dirty_v, lru_v, mru_v, skip_v, cand_v;
  logic [SLOTS-1:0] hit_oh, free_oh, lru_oh, fl_oh, rest_v, sel_oh;
  logic             hit_any, free_any, flush_last, sel_dirty, emit;
  logic [IDX_W-1:0]    sel_idx, sel_rank;
  logic [TAG_BITS-1:0] sel_tag;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_v[i] = (stat_r[i] != ST_FREE) && (tag_r[i] == blk_r);
      free_v[i]  = (stat_r[i] == ST_FREE);
      dirty_v[i] = (stat_r[i] == ST_DIRTY);
      lru_v[i]   = (rank_r[i] == LRU_RANK);
      mru_v[i]   = (rank_r[i] == '0);
      skip_v[i]  = (act_r == ACT_FLUSH_ONE) && (i == int'(cur_r));
    end
    cand_v = dirty_v & ~skip_v;
    // lowest set bit of each request vector
    hit_oh  = match_v & (~match_v + ONE_V);
    free_oh = free_v & (~free_v + ONE_V);
    lru_oh  = (lru_v == '0) ? TOP_V : (lru_v & (~lru_v + ONE_V));
    fl_oh   = cand_v & (~cand_v + ONE_V);
    rest_v  = cand_v & ~fl_oh;
    hit_any  = |match_v;
    free_any = |free_v;
    flush_last = (act_r == ACT_FLUSH_ONE) || (rest_v == '0);

    if (act_r == ACT_ACCESS) begin
      sel_oh = hit_any ? hit_oh : (free_any ? free_oh : lru_oh);
    end else begin
      sel_oh = fl_oh;
    end

    sel_idx   = '0;
    sel_rank  = '0;
    sel_tag   = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_oh[i]) begin
        sel_idx   = sel_idx | IDX_W'(i);
        sel_rank  = sel_rank | rank_r[i];
        sel_tag   = sel_tag | tag_r[i];
        sel_dirty = sel_dirty | dirty_v[i];
      end
    end
  end

  always_comb begin
    tag_nxt  = tag_r;
    stat_nxt = stat_r;
    rank_nxt = rank_r;
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.mark && (i == int'(cur_r))) begin
        stat_nxt[i] = ST_DIRTY;
      end
      if (cmd.access) begin
        // move selected slot to the front, age the ones ahead of it
        if (rank_r[i] < sel_rank) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
        if (sel_oh[i]) begin
          rank_nxt[i] = '0;
          if (!hit_any) begin
            stat_nxt[i] = ST_FULL;
            tag_nxt[i]  = blk_r;
          end
        end
      end
      if (cmd.flush && sel_oh[i]) begin
        stat_nxt[i] = ST_FULL;
      end
    end
  end

  assign emit = cmd.access || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i]  <= '0;
        stat_r[i] <= ST_FREE;
        rank_r[i] <= IDX_W'(i);
      end
      out_valid_r <= 1'b0;
    end else begin
      tag_r  <= tag_nxt;
      stat_r <= stat_nxt;
      rank_r <= rank_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      blk_r <= TAG_BITS'(in_block_number);
      cur_r <= in_slot_index;
    end
    if (emit) begin
      out_slot_r <= SLOT_W'(sel_idx);
      out_hit_r  <= cmd.access && hit_any;
      out_wb_r   <= cmd.flush || (!hit_any && !free_any && sel_dirty);
      out_wbb_r  <= (cmd.flush || (!hit_any && !free_any && sel_dirty))
                    ? BLOCK_W'(sel_tag) : '0;
      out_last_r <= cmd.access || flush_last;
    end
  end

  assign sts.act         = act_r;
  assign sts.dirty_found = |cand_v;
  assign sts.flush_last  = flush_last;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_slot             = out_slot_r;
  assign out_hit              = out_hit_r;
  assign out_write_back       = out_wb_r;
  assign out_write_back_block = out_wbb_r;
  assign out_last             = out_last_r;

`ifndef SYNTHESIS
  a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n) $onehot(lru_v))
    else $error("LRU rank not held by exactly one slot");
  a_mru_unique: assert property (@(posedge clk) disable iff (!rst_n) $onehot(mru_v))
    else $error("MRU rank not held by exactly one slot");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while occupied");
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.access && hit_any) |=> (out_valid_r && out_hit_r && !out_wb_r && out_last_r))
    else $error("hit produced a write-back");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

import lsc_pkg::*;

module tb_top;

  localparam int NSLOTS      = 8;
  localparam int TAG_POOL    = 12;    // a few more tags than slots, so hits and evictions mix
  localparam int PHASE_ITEMS = 115;   // random transactions per idling phase
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off, long enough to back up the input
  localparam int TAIL_CYCLES = 20;    // settle time once nothing is due
  localparam int STALL_LIMIT = 2000;  // cycles without any transaction before giving up

  // One result transaction, as the directory reports it
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               write_back;
    logic [BLOCK_W-1:0] write_back_block;
    logic               last;
  } dir_reply_t;

  // ---------------------------------------------------------------------------
  // Shadow directory: tags, status and LRU ranks, plus the replies still owed
  // ---------------------------------------------------------------------------
  class dir_tracker;
    logic [BLOCK_W-1:0] tag    [NSLOTS];
    status_t            status [NSLOTS];
    logic [SLOT_W-1:0]  rank   [NSLOTS];
    dir_reply_t         due_replies [$];
    int unsigned        failures;

    function new();
      for (int s = 0; s < NSLOTS; s++) begin
        tag[s]    = '0;
        status[s] = ST_FREE;
        rank[s]   = SLOT_W'(s);
      end
      failures = 0;
    endfunction

    // make slot s the most recent; everything younger ages by one
    function void touch(int s);
      logic [SLOT_W-1:0] r;
      r = rank[s];
      if (r == 0) return;
      for (int i = 0; i < NSLOTS; i++)
        if (rank[i] < r) rank[i]++;
      rank[s] = '0;
    endfunction

    function void owe(int s, logic hit, logic wb, logic [BLOCK_W-1:0] wb_tag, logic last);
      dir_reply_t r;
      r.slot             = SLOT_W'(s);
      r.hit              = hit;
      r.write_back       = wb;
      r.write_back_block = wb ? wb_tag : '0;
      r.last             = last;
      due_replies.push_back(r);
    endfunction

    // update the shadow state for one accepted request, queue what it owes
    function void note_request(action_t act, logic [BLOCK_W-1:0] blk,
                               logic [SLOT_W-1:0] idx);
      int          victim;
      logic        wb;
      logic [BLOCK_W-1:0] wb_tag;
      int unsigned n;
      bit          done;
      victim = -1;
      wb     = 1'b0;
      wb_tag = '0;
      n      = 0;
      done   = 1'b0;
      case (act)
        ACT_ACCESS: begin
          // free slots never match, whatever tag they still hold
          for (int s = 0; s < NSLOTS; s++)
            if (victim < 0 && status[s] != ST_FREE && tag[s] == blk) victim = s;
          if (victim >= 0) begin
            touch(victim);
            owe(victim, 1'b1, 1'b0, '0, 1'b1);
          end else begin
            for (int s = 0; s < NSLOTS; s++)
              if (victim < 0 && status[s] == ST_FREE) victim = s;
            if (victim < 0) begin
              victim = NSLOTS - 1;
              for (int s = NSLOTS - 1; s >= 0; s--)
                if (rank[s] == NSLOTS - 1) victim = s;
              if (status[victim] == ST_DIRTY) begin
                wb     = 1'b1;
                wb_tag = tag[victim];
              end
            end
            status[victim] = ST_FULL;
            tag[victim]    = blk;
            touch(victim);
            owe(victim, 1'b0, wb, wb_tag, 1'b1);
          end
        end
        ACT_MARK: status[idx] = ST_DIRTY;  // a free slot goes dirty with its old tag
        ACT_FLUSH_ONE: begin
          for (int s = 0; s < NSLOTS; s++)
            if (!done && s != idx && status[s] == ST_DIRTY) begin
              status[s] = ST_FULL;
              owe(s, 1'b0, 1'b1, tag[s], 1'b1);
              done = 1'b1;
            end
        end
        default: begin
          for (int s = 0; s < NSLOTS; s++)
            if (status[s] == ST_DIRTY) begin
              status[s] = ST_FULL;
              owe(s, 1'b0, 1'b1, tag[s], 1'b0);
              n++;
            end
          if (n > 0) due_replies[$].last = 1'b1;
        end
      endcase
    endfunction

    function void check_reply(dir_reply_t got);
      dir_reply_t want;
      if (due_replies.size() == 0) begin
        $error("result with nothing due: slot %0d hit %0b wb %0b tag %h last %0b",
               got.slot, got.hit, got.write_back, got.write_back_block, got.last);
        failures++;
        return;
      end
      want = due_replies.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        failures++;
      end
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, got %0b", want.hit, got.hit);
        failures++;
      end
      if (got.write_back !== want.write_back) begin
        $error("write_back: expected %0b, got %0b", want.write_back, got.write_back);
        failures++;
      end
      if (got.write_back_block !== want.write_back_block) begin
        $error("write_back_block: expected %h, got %h",
               want.write_back_block, got.write_back_block);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  lsc_in_if  in_ch ();
  lsc_out_if out_ch ();

  lru_slot_cache_core #(
    .SLOTS    (NSLOTS),
    .TAG_BITS (BLOCK_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  dir_tracker         dir;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        hold_reqs;      // bumped by the sequence to ask for a hold-off
  int unsigned        hold_seen;      // receiver's copy of the last request served
  int unsigned        recv_hold;
  int unsigned        quiet_cycles;
  logic [BLOCK_W-1:0] tag_pool [TAG_POOL];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, or a counted hold-off when one is asked for
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    recv_hold    = 0;
    hold_seen    = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        recv_hold = HOLD_CYCLES;
      end
      if (recv_hold != 0) begin
        out_ch.ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the edge. A request feeds the shadow
  // directory before any result of the same edge is checked; results always
  // trail their request, so the order is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        dir.note_request(action_t'(in_ch.action), in_ch.block_number, in_ch.slot_index);
      if (out_ch.valid && out_ch.ready)
        dir.check_reply(dir_reply_t'{out_ch.slot, out_ch.hit, out_ch.write_back,
                                     out_ch.write_back_block, out_ch.last});
    end
  end

  // Watchdog: a long run of edges with no transaction on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** lru_slot_cache_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------

  // Offer one request; returns on the edge that accepted it with valid still
  // high, so a following request goes out back to back.
  task automatic send_request(action_t act, logic [BLOCK_W-1:0] blk,
                              logic [SLOT_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.block_number <= blk;
    in_ch.slot_index   <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic go_quiet();
    in_ch.valid <= 1'b0;
  endtask

  // Sender stays silent until every owed result has turned up, after first
  // letting the monitor book the last accepted request
  task automatic drain();
    go_quiet();
    @(posedge clk);
    while (dir.due_replies.size() != 0) @(posedge clk);
  endtask

  // Mostly lookups on a small tag set; marks often enough that evictions
  // and flushes have dirty blocks to write out
  task automatic send_random();
    action_t            act;
    logic [BLOCK_W-1:0] blk;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 55)      act = ACT_ACCESS;
    else if (pick < 78) act = ACT_MARK;
    else if (pick < 92) act = ACT_FLUSH_ONE;
    else                act = ACT_FLUSH_ALL;
    if ($urandom_range(9) == 0) blk = BLOCK_W'($urandom);
    else                        blk = tag_pool[$urandom_range(TAG_POOL - 1)];
    send_request(act, blk, SLOT_W'($urandom_range(NSLOTS - 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idle_tab  [4];
    int unsigned stall_tab [4];
    dir = new();
    idle_tab  = '{0, 50, 0, 36};
    stall_tab = '{0, 0, 50, 36};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_ACCESS;
    in_ch.block_number = '0;
    in_ch.slot_index   = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_reqs          = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty directory, tag zero vs free slots, marking a free slot,
    // flush skipping the current slot, flushes with nothing dirty, a dirty
    // LRU victim and a flush all with many write-backs.
    send_request(ACT_ACCESS,    16'h0000, 3'd0);  // miss although free slots hold zero
    send_request(ACT_ACCESS,    16'hFFFF, 3'd7);
    send_request(ACT_ACCESS,    16'h0000, 3'd0);  // hit
    send_request(ACT_MARK,      16'hFFFF, 3'd7);  // free slot turns dirty, tag zero
    send_request(ACT_ACCESS,    16'h0000, 3'd5);
    send_request(ACT_FLUSH_ONE, 16'h0000, 3'd7);  // only dirty slot is the current one
    send_request(ACT_FLUSH_ONE, 16'hFFFF, 3'd0);
    send_request(ACT_FLUSH_ALL, 16'h0000, 3'd3);  // nothing dirty: no result
    send_request(ACT_ACCESS,    16'h1234, 3'd1);
    send_request(ACT_ACCESS,    16'h5678, 3'd2);
    send_request(ACT_ACCESS,    16'h9ABC, 3'd4);
    send_request(ACT_ACCESS,    16'hDEF0, 3'd6);
    send_request(ACT_ACCESS,    16'h8001, 3'd3);
    send_request(ACT_MARK,      16'h0000, 3'd7);
    send_request(ACT_MARK,      16'h0000, 3'd2);
    send_request(ACT_MARK,      16'h0000, 3'd4);
    send_request(ACT_ACCESS,    16'h4242, 3'd7);  // full: evicts dirty LRU slot
    send_request(ACT_FLUSH_ONE, 16'h0000, 3'd2);
    send_request(ACT_MARK,      16'h0000, 3'd3);
    send_request(ACT_MARK,      16'h0000, 3'd5);
    send_request(ACT_MARK,      16'h0000, 3'd6);
    send_request(ACT_MARK,      16'h0000, 3'd0);
    send_request(ACT_MARK,      16'h0000, 3'd1);
    send_request(ACT_FLUSH_ALL, 16'hFFFF, 3'd0);  // several write-backs, last on the final one
    send_request(ACT_ACCESS,    16'hFFFF, 3'd0);
    drain();

    // Random phases under different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      foreach (tag_pool[k]) tag_pool[k] = BLOCK_W'($urandom);
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      // receiver sits out a long stretch while requests keep coming
      if (ph == 0) hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      drain();
    end

    // idle settle: a late or spurious result still gets caught
    repeat (TAIL_CYCLES) @(posedge clk);
    if (dir.failures == 0 && dir.due_replies.size() == 0) begin
      $display("** lru_slot_cache_core: PASSED **");
    end else begin
      $display("** lru_slot_cache_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lsc_pkg.sv
src/lsc_if.sv
src/lsc_ctrl.sv
src/lsc_datapath.sv
src/lru_slot_cache_core.sv
sim/tb_top.sv
